FILE: rtl/vsfe_pkg.sv
// Shared types and constants for the VM status field extractor.
package vsfe_pkg;

    localparam int VALUE_BITS_DEFAULT = 31;
    localparam int CODE_BITS = 3;
    localparam int BYTE_BITS = 8;

    localparam logic [BYTE_BITS-1:0] CH_V       = 8'h56;
    localparam logic [BYTE_BITS-1:0] CH_M_LOWER = 8'h6d;
    localparam logic [BYTE_BITS-1:0] CH_R       = 8'h52;
    localparam logic [BYTE_BITS-1:0] CH_D       = 8'h44;
    localparam logic [BYTE_BITS-1:0] CH_S       = 8'h53;
    localparam logic [BYTE_BITS-1:0] CH_E       = 8'h45;
    localparam logic [BYTE_BITS-1:0] CH_L       = 8'h4c;
    localparam logic [BYTE_BITS-1:0] CH_T_LOWER = 8'h74;
    localparam logic [BYTE_BITS-1:0] CH_I_LOWER = 8'h69;
    localparam logic [BYTE_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_BITS-1:0] CH_NEWLINE = 8'h0a;

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_GOT_V      = 4'd1,
        PH_GOT_VM     = 4'd2,
        PH_GOT_VMS    = 4'd3,
        PH_GOT_VML    = 4'd4,
        PH_WAIT_DIGIT = 4'd5,
        PH_DIGITS     = 4'd6,
        PH_SKIP_LINE  = 4'd7
    } phase_t;

    typedef enum logic [CODE_BITS-1:0] {
        FC_RSS   = 3'd0,
        FC_DATA  = 3'd1,
        FC_STACK = 3'd2,
        FC_SIZE  = 3'd3,
        FC_EXE   = 3'd4,
        FC_LIB   = 3'd5
    } field_code_t;

    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] text_byte;
        logic                 start_of_text;
    } in_item_t;

endpackage

FILE: rtl/vsfe_in_stage.sv
// Input register that holds one accepted text byte for the parser.
module vsfe_in_stage
    import vsfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_BITS-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 advance,
    output in_item_t             item
);

    logic                 valid_reg;
    logic [BYTE_BITS-1:0] byte_reg;
    logic                 start_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    assign item.valid         = valid_reg;
    assign item.text_byte     = byte_reg;
    assign item.start_of_text = start_reg;

endmodule

FILE: rtl/vsfe_parser.sv
// Line parser state machine with the decimal accumulator.
module vsfe_parser
    import vsfe_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              item,
    input  logic                  advance,
    output logic                  res_valid,
    output field_code_t           res_code,
    output logic [VALUE_BITS-1:0] res_value
);

    localparam int WIDE_BITS = VALUE_BITS + 4;

    phase_t                phase_reg, phase_next;
    field_code_t           field_reg, field_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;

    phase_t                phase_cur;
    field_code_t           field_cur;
    logic [VALUE_BITS-1:0] acc_cur;
    logic                  is_digit;
    logic                  is_newline;
    logic [3:0]            digit;
    logic [WIDE_BITS-1:0]  wide_sum;
    logic [VALUE_BITS-1:0] acc_added;
    phase_t                phase_other;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            field_reg <= FC_RSS;
            acc_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            field_reg <= field_next;
            acc_reg   <= acc_next;
        end
    end

    always_comb
    begin
        phase_cur   = item.start_of_text ? PH_LINE_START : phase_reg;
        field_cur   = item.start_of_text ? FC_RSS : field_reg;
        acc_cur     = item.start_of_text ? '0 : acc_reg;
        is_digit    = (item.text_byte >= CH_ZERO) && (item.text_byte <= CH_NINE);
        is_newline  = (item.text_byte == CH_NEWLINE);
        digit       = item.text_byte[3:0];
        phase_other = is_newline ? PH_LINE_START : PH_SKIP_LINE;
        wide_sum    = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
                    + {{(WIDE_BITS-4){1'b0}}, digit};
        if (wide_sum[WIDE_BITS-1:VALUE_BITS] != '0)
        begin
            acc_added = '1;
        end
        else
        begin
            acc_added = wide_sum[VALUE_BITS-1:0];
        end

        phase_next = phase_cur;
        field_next = field_cur;
        acc_next   = acc_cur;
        res_valid  = 1'b0;
        res_code   = field_cur;
        res_value  = acc_cur;

        case (phase_cur)
            PH_LINE_START:
            begin
                phase_next = (item.text_byte == CH_V) ? PH_GOT_V : phase_other;
            end
            PH_GOT_V:
            begin
                phase_next = (item.text_byte == CH_M_LOWER) ? PH_GOT_VM : phase_other;
            end
            PH_GOT_VM:
            begin
                if (item.text_byte == CH_R || item.text_byte == CH_D
                    || item.text_byte == CH_E)
                begin
                    phase_next = PH_WAIT_DIGIT;
                    acc_next   = '0;
                    if (item.text_byte == CH_R)
                    begin
                        field_next = FC_RSS;
                    end
                    else if (item.text_byte == CH_D)
                    begin
                        field_next = FC_DATA;
                    end
                    else
                    begin
                        field_next = FC_EXE;
                    end
                end
                else if (item.text_byte == CH_S)
                begin
                    phase_next = PH_GOT_VMS;
                end
                else if (item.text_byte == CH_L)
                begin
                    phase_next = PH_GOT_VML;
                end
                else
                begin
                    phase_next = phase_other;
                end
            end
            PH_GOT_VMS:
            begin
                if (item.text_byte == CH_T_LOWER || item.text_byte == CH_I_LOWER)
                begin
                    phase_next = PH_WAIT_DIGIT;
                    acc_next   = '0;
                    field_next = (item.text_byte == CH_T_LOWER) ? FC_STACK : FC_SIZE;
                end
                else
                begin
                    phase_next = phase_other;
                end
            end
            PH_GOT_VML:
            begin
                if (item.text_byte == CH_I_LOWER)
                begin
                    phase_next = PH_WAIT_DIGIT;
                    acc_next   = '0;
                    field_next = FC_LIB;
                end
                else
                begin
                    phase_next = phase_other;
                end
            end
            PH_WAIT_DIGIT:
            begin
                if (is_digit)
                begin
                    acc_next   = {{(VALUE_BITS-4){1'b0}}, digit};
                    phase_next = PH_DIGITS;
                end
                else if (is_newline)
                begin
                    phase_next = PH_LINE_START;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    acc_next = acc_added;
                end
                else
                begin
                    res_valid  = 1'b1;
                    phase_next = phase_other;
                end
            end
            default:
            begin
                phase_next = is_newline ? PH_LINE_START : PH_SKIP_LINE;
            end
        endcase
    end

endmodule

FILE: rtl/vsfe_out_stage.sv
// Result register that holds one field code and value for the receiver.
module vsfe_out_stage
    import vsfe_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
    parameter int DATA_BITS  = ((CODE_BITS + VALUE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  res_valid,
    input  field_code_t           res_code,
    input  logic [VALUE_BITS-1:0] res_value,
    output logic                  advance,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_BITS-1:0]  m_tdata
);

    localparam int PAD_BITS = DATA_BITS - CODE_BITS - VALUE_BITS;

    logic                  valid_reg;
    logic                  free;
    field_code_t           code_reg;
    logic [VALUE_BITS-1:0] value_reg;

    assign free    = !valid_reg || m_tready;
    assign advance = in_valid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            code_reg  <= res_code;
            value_reg <= res_value;
        end
    end

    assign m_tvalid = valid_reg;
    generate
        if (PAD_BITS > 0)
        begin : g_pad
            assign m_tdata = {{PAD_BITS{1'b0}}, value_reg, code_reg};
        end
        else
        begin : g_nopad
            assign m_tdata = {value_reg, code_reg};
        end
    endgenerate

endmodule

FILE: rtl/vm_status_field_extractor_top.sv
// Top level of the VM status field extractor.
// The block reads a status text one byte per item on the slave channel and
// emits one item on the master channel for each recognised memory line,
// carrying the field code and its decimal value, saturated at the top of
// the value range.
// An accepted byte is first held in an input register; the parser updates
// its state from that register and writes any result into the output
// register when that byte advances, so a result is presented from the output
// register once the byte that ends its digits has passed the parser.
// One byte is taken every cycle while the output register is empty or m_tready
// is high; the parser state and the single output register set that rate.
// When the receiver stalls, the output register holds its item, the input
// register fills, and s_tready falls until m_tready returns; nothing is lost.
// Setting tuser on a byte restarts the parser at the start of a line.
// Reset empties both registers and puts the parser at the start of a line.
module vm_status_field_extractor_top
    import vsfe_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
    parameter int DATA_BITS  = ((CODE_BITS + VALUE_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_BITS-1:0] s_tdata,   // text_byte
    input  logic                 s_tuser,   // start_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata    // field_code, field_value, zero fill
);

    in_item_t              item;
    logic                  advance;
    logic                  res_valid;
    field_code_t           res_code;
    logic [VALUE_BITS-1:0] res_value;

    vsfe_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .item     (item)
    );

    vsfe_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .advance   (advance),
        .res_valid (res_valid),
        .res_code  (res_code),
        .res_value (res_value)
    );

    vsfe_out_stage #(
        .VALUE_BITS (VALUE_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .res_valid (res_valid),
        .res_code  (res_code),
        .res_value (res_value),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
